### src/spherical_shell_clearance_unit_macros.svh
`ifndef SPHERICAL_SHELL_CLEARANCE_UNIT_MACROS_SVH
`define SPHERICAL_SHELL_CLEARANCE_UNIT_MACROS_SVH
// Assertion helpers shared by the shell clearance unit.
// The condition on the right must hold in the same cycle as the one on the left.
`define SSCU_ASSERT_HOLDS(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// The condition on the right must hold in the cycle after the one on the left.
`define SSCU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

### src/sscu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Shell clearance package
// Shared constants, codes and types of the spherical shell clearance unit.
// ----------------------------------------------------------------------------
package sscu_pkg;

   localparam int COORD_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF   = 16;
   localparam int NORM_FRAC       = 30;
   localparam int NORM_WIDTH      = 32;
   localparam int CSR_INDEX_WIDTH = 3;

   // Divider lanes: three closest-point axes, three normal axes, inverse radius.
   localparam int DIV_LANES    = 7;
   localparam int LANE_CLOSEST = 0;
   localparam int LANE_NORMAL  = 3;
   localparam int LANE_INV     = 6;

   localparam logic [1:0] OP_NEAREST = 2'd0;
   localparam logic [1:0] OP_INNER   = 2'd1;
   localparam logic [1:0] OP_OUTER   = 2'd2;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CENTER_X  = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CENTER_Y  = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CENTER_Z  = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_REF_RAD   = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_INNER_THK = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_OUTER_THK = 3'd5;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_AT_CENTER = 2'd1,
      ST_INNER_BAD = 2'd2
   } status_type;

   typedef struct packed {
      logic [1:0] op;
      status_type status;
   } ctrl_type;

   // Quotient bits a divider cell row must produce so that every quotient fits.
   function automatic int quot_bits(input int cw, input int fb);
      int q;
      q = cw + 1;
      if (2 * fb + 1 > q) q = 2 * fb + 1;
      if (NORM_WIDTH > q) q = NORM_WIDTH;
      return q;
   endfunction

endpackage
`default_nettype wire

### src/sscu_sqrt_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Square root cell
// One restoring digit step of the integer square root, registered.
// ----------------------------------------------------------------------------
module sscu_sqrt_cell #(
   parameter int COORD_WIDTH = sscu_pkg::COORD_WIDTH_DEF,
   parameter int SIDE_WIDTH  = 1,
   localparam int RW = COORD_WIDTH + 1,
   localparam int SW = 2 * RW
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   output logic                    in_ready,
   input  wire sscu_pkg::ctrl_type in_ctrl,
   input  wire logic [RW+1:0]      in_rem,
   input  wire logic [RW-1:0]      in_root,
   input  wire logic [SW-1:0]      in_rad,
   input  wire logic [SIDE_WIDTH-1:0] in_side,
   output logic                    out_valid,
   input  wire logic               out_ready,
   output sscu_pkg::ctrl_type      out_ctrl,
   output logic [RW+1:0]           out_rem,
   output logic [RW-1:0]           out_root,
   output logic [SW-1:0]           out_rad,
   output logic [SIDE_WIDTH-1:0]   out_side
);

   logic               valid_ff, valid_in;
   sscu_pkg::ctrl_type ctrl_ff;
   logic [RW+1:0]      rem_ff, rem_in;
   logic [RW-1:0]      root_ff, root_in;
   logic [SW-1:0]      rad_ff, rad_in;
   logic [SIDE_WIDTH-1:0] side_ff;
   logic [RW+3:0]      trial, rest;
   logic               ge;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_comb begin
      rest    = {in_rem, in_rad[SW-1:SW-2]};
      trial   = {2'b00, in_root, 2'b01};
      ge      = rest >= trial;
      // The partial remainder stays within RW+2 bits either way.
      rem_in  = ge ? (RW+2)'(rest - trial) : rest[RW+1:0];
      root_in = {in_root[RW-2:0], ge};
      rad_in  = {in_rad[SW-3:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         ctrl_ff <= in_ctrl;
         rem_ff  <= rem_in;
         root_ff <= root_in;
         rad_ff  <= rad_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_ctrl  = ctrl_ff;
   assign out_rem   = rem_ff;
   assign out_root  = root_ff;
   assign out_rad   = rad_ff;
   assign out_side  = side_ff;

endmodule
`default_nettype wire

### src/sscu_div_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Divider cell
// One restoring quotient bit for each divider lane, all sharing one divisor.
// ----------------------------------------------------------------------------
`include "spherical_shell_clearance_unit_macros.svh"
module sscu_div_cell #(
   parameter int COORD_WIDTH = sscu_pkg::COORD_WIDTH_DEF,
   parameter int FRAC_BITS   = sscu_pkg::FRAC_BITS_DEF,
   parameter int SIDE_WIDTH  = 1,
   localparam int RW = COORD_WIDTH + 1,
   localparam int QB = sscu_pkg::quot_bits(COORD_WIDTH, FRAC_BITS),
   localparam int LN = sscu_pkg::DIV_LANES
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   output logic                    in_ready,
   input  wire sscu_pkg::ctrl_type in_ctrl,
   input  wire logic [RW-1:0]      in_div,
   input  wire logic [LN*RW-1:0]   in_rem,
   input  wire logic [LN*QB-1:0]   in_nq,
   input  wire logic [SIDE_WIDTH-1:0] in_side,
   output logic                    out_valid,
   input  wire logic               out_ready,
   output sscu_pkg::ctrl_type      out_ctrl,
   output logic [RW-1:0]           out_div,
   output logic [LN*RW-1:0]        out_rem,
   output logic [LN*QB-1:0]        out_nq,
   output logic [SIDE_WIDTH-1:0]   out_side
);

   logic               valid_ff, valid_in;
   sscu_pkg::ctrl_type ctrl_ff;
   logic [RW-1:0]      div_ff;
   logic [LN*RW-1:0]   rem_ff, rem_in;
   logic [LN*QB-1:0]   nq_ff, nq_in;
   logic [SIDE_WIDTH-1:0] side_ff;
   logic [LN-1:0]      below;
   logic               rem_ok;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   // The numerator's next bit joins the partial remainder; the quotient bit
   // shifts in at the bottom as the numerator bits move out at the top.
   for (genvar i = 0; i < LN; i++) begin : g_lane
      logic [RW:0] part, diff;
      logic        ge;
      assign part = {in_rem[i*RW +: RW], in_nq[i*QB + QB - 1]};
      assign diff = part - {1'b0, in_div};
      assign ge   = part >= {1'b0, in_div};
      assign rem_in[i*RW +: RW] = ge ? diff[RW-1:0] : part[RW-1:0];
      assign nq_in[i*QB +: QB]  = {in_nq[i*QB +: QB-1], ge};
      assign below[i] = rem_ff[i*RW +: RW] < div_ff;
   end

   assign rem_ok = &below;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         ctrl_ff <= in_ctrl;
         div_ff  <= in_div;
         rem_ff  <= rem_in;
         nq_ff   <= nq_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_ctrl  = ctrl_ff;
   assign out_div   = div_ff;
   assign out_rem   = rem_ff;
   assign out_nq    = nq_ff;
   assign out_side  = side_ff;

   `SSCU_ASSERT_HOLDS(a_rem_below_divisor, clock, reset, valid_ff && ctrl_ff.status == sscu_pkg::ST_OK, rem_ok, "divider remainder not below divisor")

endmodule
`default_nettype wire

### src/spherical_shell_clearance_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Spherical shell clearance unit
// Signed clearance, closest point, normal and inverse radius of a point
// with respect to the inner or outer sphere of a configured shell.
// ----------------------------------------------------------------------------
// Usage:
// The req_ channel takes one query point per beat: opcode in tuser, the three
// coordinates in tdata. The rsp_ channel returns one result beat per query in
// order: status and boundary id in tuser, the numeric fields in tdata.
// Shell center, reference radius and both thicknesses are written through the
// csr_ port while no query is in flight.
// Throughput is one beat per cycle while rsp_tready does not stall the pipe.
// Each query passes stages A to C, the square root row, one result bit per
// cell, stages M1 and M2, the divider row, one quotient bit per cell for
// all seven divisions at once, and the output stage. QB is the quotient
// width of the divider row; the default format is Q16.16.
// Each pipeline stage stalls only when it is full and the stage after it is
// stalled, so a response waiting on rsp_tready does not stop request beats
// until the empty stages in front of it have filled.
// Reset empties the pipeline and returns the registers to a shell centered
// at the origin with a reference radius of 1.0 and zero thickness.
// ----------------------------------------------------------------------------
`include "spherical_shell_clearance_unit_macros.svh"
module spherical_shell_clearance_unit #(
   parameter int COORD_WIDTH = sscu_pkg::COORD_WIDTH_DEF,
   parameter int FRAC_BITS   = sscu_pkg::FRAC_BITS_DEF,
   localparam int IN_TDW  = ((3 * COORD_WIDTH + 7) / 8) * 8,
   localparam int OUT_BW  = 5 * COORD_WIDTH + 3 * sscu_pkg::NORM_WIDTH + 1,
   localparam int OUT_TDW = ((OUT_BW + 7) / 8) * 8
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   // Register write port.
   input  wire logic                 csr_we,
   input  wire logic [sscu_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [COORD_WIDTH-1:0] csr_wdata,
   // Query beats.
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   // tdata, low bit up: point_x, point_y, point_z.
   input  wire logic [IN_TDW-1:0]    req_tdata,
   // tuser: opcode.
   input  wire logic [1:0]           req_tuser,
   // Result beats.
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   // tdata, low bit up: clearance, closest_x, closest_y, closest_z, normal_x,
   // normal_y, normal_z, admissible, inv_radius, zero fill.
   output logic [OUT_TDW-1:0]        rsp_tdata,
   // tuser, low bit up: status, boundary_id.
   output logic [2:0]                rsp_tuser
);

   localparam int CW  = COORD_WIDTH;
   localparam int DW  = CW + 1;         // magnitude of a coordinate offset
   localparam int RW  = CW + 1;         // radius
   localparam int SW  = 2 * RW;         // squared radius
   localparam int QB  = sscu_pkg::quot_bits(CW, FRAC_BITS);
   localparam int NW  = QB + RW;        // divider numerator
   localparam int LN  = sscu_pkg::DIV_LANES;
   localparam int NMW = sscu_pkg::NORM_WIDTH;
   localparam int SSW = 3 * DW + 3;     // side data through the square root
   localparam int DSW = CW + 5;         // side data through the divider
   localparam logic [QB-1:0]  NORM_ONE  = QB'(1) << sscu_pkg::NORM_FRAC;
   localparam logic [NMW-1:0] NORM_ONE_OUT = NMW'(1) << sscu_pkg::NORM_FRAC;
   localparam logic [NW-1:0]  INV_NUM   = NW'(1) << (2 * FRAC_BITS);

   // ---------------------------------------------------------------------
   // Configuration registers.
   // ---------------------------------------------------------------------
   logic [CW-1:0] center_ff [3];
   logic [CW-2:0] ref_rad_ff, inner_thk_ff, outer_thk_ff;
   logic [CW:0]   inner;            // signed inner radius
   logic [CW-1:0] outer;            // unsigned outer radius
   logic          inner_bad;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_ff[0] <= '0;
         center_ff[1] <= '0;
         center_ff[2] <= '0;
         ref_rad_ff   <= (CW-1)'(1) << FRAC_BITS;
         inner_thk_ff <= '0;
         outer_thk_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            sscu_pkg::CSR_CENTER_X:  center_ff[0] <= csr_wdata;
            sscu_pkg::CSR_CENTER_Y:  center_ff[1] <= csr_wdata;
            sscu_pkg::CSR_CENTER_Z:  center_ff[2] <= csr_wdata;
            sscu_pkg::CSR_REF_RAD:   ref_rad_ff   <= csr_wdata[CW-2:0];
            sscu_pkg::CSR_INNER_THK: inner_thk_ff <= csr_wdata[CW-2:0];
            sscu_pkg::CSR_OUTER_THK: outer_thk_ff <= csr_wdata[CW-2:0];
            default: begin
            end
         endcase
      end
   end

   // The radii follow from the registers, which the user keeps stable while
   // queries are in flight (unenforced), so every stage reads them as needed.
   assign inner     = {2'b00, ref_rad_ff} - {2'b00, inner_thk_ff};
   assign outer     = {1'b0, ref_rad_ff} + {1'b0, outer_thk_ff};
   assign inner_bad = inner[CW] || (inner == '0);

   // ---------------------------------------------------------------------
   // Stage A: offsets from the center, split into magnitude and sign.
   // ---------------------------------------------------------------------
   logic               a_ready, a_valid_ff, a_valid_in;
   sscu_pkg::ctrl_type a_ctrl_ff, a_ctrl_in;
   logic [DW-1:0]      a_mag_ff [3], a_mag_in [3];
   logic [2:0]         a_neg_ff, a_neg_in;
   logic [CW:0]        offs [3];
   logic               b_ready;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         offs[i] = {req_tdata[i*CW + CW - 1], req_tdata[i*CW +: CW]}
                 - {center_ff[i][CW-1], center_ff[i]};
         a_neg_in[i] = offs[i][CW];
         a_mag_in[i] = offs[i][CW] ? ({DW{1'b0}} - offs[i]) : offs[i];
      end
      a_ctrl_in.op = req_tuser;
      if (inner_bad) begin
         a_ctrl_in.status = sscu_pkg::ST_INNER_BAD;
      end else if (offs[0] == '0 && offs[1] == '0 && offs[2] == '0) begin
         a_ctrl_in.status = sscu_pkg::ST_AT_CENTER;
      end else begin
         a_ctrl_in.status = sscu_pkg::ST_OK;
      end
   end

   assign a_ready    = !a_valid_ff || b_ready;
   assign req_tready = a_ready;
   assign a_valid_in = a_ready ? req_tvalid : a_valid_ff;

   // ---------------------------------------------------------------------
   // Stage B: squares of the offset magnitudes.
   // ---------------------------------------------------------------------
   logic               b_valid_ff, b_valid_in;
   sscu_pkg::ctrl_type b_ctrl_ff;
   logic [2*DW-1:0]    b_sq_ff [3];
   logic [SSW-1:0]     b_side_ff;
   logic               c_ready;

   assign b_ready    = !b_valid_ff || c_ready;
   assign b_valid_in = b_ready ? a_valid_ff : b_valid_ff;

   // ---------------------------------------------------------------------
   // Stage C: squared radius. The true sum stays below 2^SW.
   // ---------------------------------------------------------------------
   logic               c_valid_ff, c_valid_in;
   sscu_pkg::ctrl_type c_ctrl_ff;
   logic [SW-1:0]      c_sum_ff;
   logic [SSW-1:0]     c_side_ff;

   // Square root row: node k feeds cell k, node RW is the finished root.
   logic               sq_valid [RW+1];
   logic               sq_ready [RW+1];
   sscu_pkg::ctrl_type sq_ctrl  [RW+1];
   logic [RW+1:0]      sq_rem   [RW+1];
   logic [RW-1:0]      sq_root  [RW+1];
   logic [SW-1:0]      sq_rad   [RW+1];
   logic [SSW-1:0]     sq_side  [RW+1];

   assign c_ready    = !c_valid_ff || sq_ready[0];
   assign c_valid_in = c_ready ? b_valid_ff : c_valid_ff;

   assign sq_valid[0] = c_valid_ff;
   assign sq_ctrl[0]  = c_ctrl_ff;
   assign sq_rem[0]   = '0;
   assign sq_root[0]  = '0;
   assign sq_rad[0]   = c_sum_ff;
   assign sq_side[0]  = c_side_ff;

   for (genvar k = 0; k < RW; k++) begin : g_sqrt
      sscu_sqrt_cell #(
         .COORD_WIDTH (COORD_WIDTH),
         .SIDE_WIDTH  (SSW)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (sq_valid[k]),
         .in_ready  (sq_ready[k]),
         .in_ctrl   (sq_ctrl[k]),
         .in_rem    (sq_rem[k]),
         .in_root   (sq_root[k]),
         .in_rad    (sq_rad[k]),
         .in_side   (sq_side[k]),
         .out_valid (sq_valid[k+1]),
         .out_ready (sq_ready[k+1]),
         .out_ctrl  (sq_ctrl[k+1]),
         .out_rem   (sq_rem[k+1]),
         .out_root  (sq_root[k+1]),
         .out_rad   (sq_rad[k+1]),
         .out_side  (sq_side[k+1])
      );
   end

   // ---------------------------------------------------------------------
   // Stage M1: boundary choice and clearance from the integer radius.
   // ---------------------------------------------------------------------
   logic               m1_ready, m1_valid_ff, m1_valid_in;
   sscu_pkg::ctrl_type m1_ctrl_ff;
   logic [RW-1:0]      m1_r_ff;
   logic [CW-1:0]      m1_bnd_ff, m1_bnd_in;     // chosen sphere radius
   logic               m1_sel_ff, m1_sel_in;
   logic [CW-1:0]      m1_clr_ff, m1_clr_in;
   logic               m1_adm_ff;
   logic [SSW-1:0]     m1_side_ff;
   logic [CW+2:0]      clr_in, clr_out, clr;
   logic [3:0]         clr_top;
   logic               m2_ready;

   always_comb begin
      clr_in  = {2'b00, sq_root[RW]} - {{2{inner[CW]}}, inner};
      clr_out = {3'b000, outer} - {2'b00, sq_root[RW]};
      case (sq_ctrl[RW].op)
         sscu_pkg::OP_INNER: m1_sel_in = 1'b0;
         sscu_pkg::OP_OUTER: m1_sel_in = 1'b1;
         default:            m1_sel_in = !($signed(clr_in) <= $signed(clr_out));
      endcase
      clr       = m1_sel_in ? clr_out : clr_in;
      m1_bnd_in = m1_sel_in ? outer : inner[CW-1:0];
      // Saturate when the bits above the result sign disagree with it.
      clr_top   = clr[CW+2:CW-1];
      if (clr_top == 4'b0000 || clr_top == 4'b1111) begin
         m1_clr_in = clr[CW-1:0];
      end else begin
         m1_clr_in = {clr[CW+2], {(CW-1){~clr[CW+2]}}};
      end
   end

   assign sq_ready[RW] = m1_ready;
   assign m1_ready     = !m1_valid_ff || m2_ready;
   assign m1_valid_in  = m1_ready ? sq_valid[RW] : m1_valid_ff;

   // ---------------------------------------------------------------------
   // Stage M2: divider numerators. Each numerator is below r * 2^QB, so its
   // top RW bits already form a remainder smaller than the divisor.
   // ---------------------------------------------------------------------
   logic               m2_valid_ff, m2_valid_in;
   sscu_pkg::ctrl_type m2_ctrl_ff;
   logic [RW-1:0]      m2_div_ff;
   logic [LN*RW-1:0]   m2_rem_ff, m2_rem_in;
   logic [LN*QB-1:0]   m2_nq_ff, m2_nq_in;
   logic [DSW-1:0]     m2_side_ff, m2_side_in;
   logic [NW-1:0]      numer [LN];
   logic [CW+DW-1:0]   prod [3];
   logic [DW-1:0]      m1_mag [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         m1_mag[i] = m1_side_ff[3 + i*DW +: DW];
         prod[i]   = m1_bnd_ff * m1_mag[i];
         numer[sscu_pkg::LANE_CLOSEST + i] = NW'(prod[i]);
         numer[sscu_pkg::LANE_NORMAL + i]  =
            NW'({m1_mag[i], {sscu_pkg::NORM_FRAC{1'b0}}});
      end
      numer[sscu_pkg::LANE_INV] = INV_NUM;
      for (int j = 0; j < LN; j++) begin
         m2_rem_in[j*RW +: RW] = numer[j][NW-1:QB];
         m2_nq_in[j*QB +: QB]  = numer[j][QB-1:0];
      end
      m2_side_in = {m1_sel_ff, m1_adm_ff, m1_side_ff[2:0], m1_clr_ff};
   end

   // Divider row: node k feeds cell k, node QB holds the quotients.
   logic               dv_valid [QB+1];
   logic               dv_ready [QB+1];
   sscu_pkg::ctrl_type dv_ctrl  [QB+1];
   logic [RW-1:0]      dv_div   [QB+1];
   logic [LN*RW-1:0]   dv_rem   [QB+1];
   logic [LN*QB-1:0]   dv_nq    [QB+1];
   logic [DSW-1:0]     dv_side  [QB+1];

   assign m2_ready    = !m2_valid_ff || dv_ready[0];
   assign m2_valid_in = m2_ready ? m1_valid_ff : m2_valid_ff;

   assign dv_valid[0] = m2_valid_ff;
   assign dv_ctrl[0]  = m2_ctrl_ff;
   assign dv_div[0]   = m2_div_ff;
   assign dv_rem[0]   = m2_rem_ff;
   assign dv_nq[0]    = m2_nq_ff;
   assign dv_side[0]  = m2_side_ff;

   for (genvar k = 0; k < QB; k++) begin : g_div
      sscu_div_cell #(
         .COORD_WIDTH (COORD_WIDTH),
         .FRAC_BITS   (FRAC_BITS),
         .SIDE_WIDTH  (DSW)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (dv_valid[k]),
         .in_ready  (dv_ready[k]),
         .in_ctrl   (dv_ctrl[k]),
         .in_div    (dv_div[k]),
         .in_rem    (dv_rem[k]),
         .in_nq     (dv_nq[k]),
         .in_side   (dv_side[k]),
         .out_valid (dv_valid[k+1]),
         .out_ready (dv_ready[k+1]),
         .out_ctrl  (dv_ctrl[k+1]),
         .out_div   (dv_div[k+1]),
         .out_rem   (dv_rem[k+1]),
         .out_nq    (dv_nq[k+1]),
         .out_side  (dv_side[k+1])
      );
   end

   // ---------------------------------------------------------------------
   // Output stage: closest point, signed normal, inverse radius, and the
   // zeroed result of either error status. These registers drive rsp_.
   // ---------------------------------------------------------------------
   logic               o_ready, rsp_valid_ff, rsp_valid_in;
   sscu_pkg::status_type rsp_status_ff, rsp_status_in;
   logic               rsp_sel_ff, rsp_sel_in;
   logic               rsp_adm_ff, rsp_adm_in;
   logic [CW-1:0]      rsp_clr_ff, rsp_clr_in;
   logic [CW-1:0]      rsp_cl_ff [3], rsp_cl_in [3];
   logic [NMW-1:0]     rsp_nm_ff [3], rsp_nm_in [3];
   logic [CW-1:0]      rsp_inv_ff, rsp_inv_in;
   logic [QB-1:0]      quo [LN];
   logic [QB+1:0]      cl_sum [3];
   logic [QB+2-CW:0]   cl_top [3];
   logic [QB-1:0]      nm_mag [3];
   logic [NMW-1:0]     nm_cut [3];
   logic               d_sel, d_adm;
   logic [2:0]         d_neg;
   logic [CW-1:0]      d_clr;
   logic               ok;

   always_comb begin
      for (int j = 0; j < LN; j++) begin
         quo[j] = dv_nq[QB][j*QB +: QB];
      end
      {d_sel, d_adm, d_neg, d_clr} = dv_side[QB];
      ok = dv_ctrl[QB].status == sscu_pkg::ST_OK;
      for (int i = 0; i < 3; i++) begin
         // Closest point: center moved toward the point by R*|d|/r.
         if (d_neg[i]) begin
            cl_sum[i] = {{(QB+2-CW){center_ff[i][CW-1]}}, center_ff[i]}
                      - {2'b00, quo[sscu_pkg::LANE_CLOSEST + i]};
         end else begin
            cl_sum[i] = {{(QB+2-CW){center_ff[i][CW-1]}}, center_ff[i]}
                      + {2'b00, quo[sscu_pkg::LANE_CLOSEST + i]};
         end
         cl_top[i] = cl_sum[i][QB+1:CW-1];
         if (cl_top[i] == '0 || cl_top[i] == '1) begin
            rsp_cl_in[i] = ok ? cl_sum[i][CW-1:0] : '0;
         end else begin
            rsp_cl_in[i] = ok ? {cl_sum[i][QB+1], {(CW-1){~cl_sum[i][QB+1]}}} : '0;
         end
         // Normal: clamp to one, then point away from the chosen boundary.
         nm_mag[i] = quo[sscu_pkg::LANE_NORMAL + i];
         nm_cut[i] = (nm_mag[i] > NORM_ONE) ? NORM_ONE_OUT : nm_mag[i][NMW-1:0];
         if (!ok) begin
            rsp_nm_in[i] = '0;
         end else if (d_neg[i] != d_sel) begin
            rsp_nm_in[i] = {NMW{1'b0}} - nm_cut[i];
         end else begin
            rsp_nm_in[i] = nm_cut[i];
         end
      end
      if (!ok) begin
         rsp_inv_in = '0;
      end else if (quo[sscu_pkg::LANE_INV][QB-1:CW] != '0) begin
         rsp_inv_in = '1;
      end else begin
         rsp_inv_in = quo[sscu_pkg::LANE_INV][CW-1:0];
      end
      rsp_status_in = dv_ctrl[QB].status;
      rsp_sel_in    = ok && d_sel;
      rsp_adm_in    = ok && d_adm;
      rsp_clr_in    = ok ? d_clr : '0;
   end

   assign dv_ready[QB]  = o_ready;
   assign o_ready       = !rsp_valid_ff || rsp_tready;
   assign rsp_valid_in  = o_ready ? dv_valid[QB] : rsp_valid_ff;

   // ---------------------------------------------------------------------
   // Registers of the front, middle and output stages.
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
         m1_valid_ff  <= 1'b0;
         m2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         a_valid_ff   <= a_valid_in;
         b_valid_ff   <= b_valid_in;
         c_valid_ff   <= c_valid_in;
         m1_valid_ff  <= m1_valid_in;
         m2_valid_ff  <= m2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (a_ready) begin
         a_ctrl_ff <= a_ctrl_in;
         a_mag_ff  <= a_mag_in;
         a_neg_ff  <= a_neg_in;
      end
      if (b_ready) begin
         b_ctrl_ff <= a_ctrl_ff;
         for (int i = 0; i < 3; i++) begin
            b_sq_ff[i] <= a_mag_ff[i] * a_mag_ff[i];
         end
         b_side_ff <= {a_mag_ff[2], a_mag_ff[1], a_mag_ff[0], a_neg_ff};
      end
      if (c_ready) begin
         c_ctrl_ff <= b_ctrl_ff;
         c_sum_ff  <= b_sq_ff[0] + b_sq_ff[1] + b_sq_ff[2];
         c_side_ff <= b_side_ff;
      end
      if (m1_ready) begin
         m1_ctrl_ff <= sq_ctrl[RW];
         m1_r_ff    <= sq_root[RW];
         m1_bnd_ff  <= m1_bnd_in;
         m1_sel_ff  <= m1_sel_in;
         m1_clr_ff  <= m1_clr_in;
         m1_adm_ff  <= !clr[CW+2];
         m1_side_ff <= sq_side[RW];
      end
      if (m2_ready) begin
         m2_ctrl_ff <= m1_ctrl_ff;
         m2_div_ff  <= m1_r_ff;
         m2_rem_ff  <= m2_rem_in;
         m2_nq_ff   <= m2_nq_in;
         m2_side_ff <= m2_side_in;
      end
      if (o_ready) begin
         rsp_status_ff <= rsp_status_in;
         rsp_sel_ff    <= rsp_sel_in;
         rsp_adm_ff    <= rsp_adm_in;
         rsp_clr_ff    <= rsp_clr_in;
         rsp_cl_ff     <= rsp_cl_in;
         rsp_nm_ff     <= rsp_nm_in;
         rsp_inv_ff    <= rsp_inv_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = {rsp_sel_ff, rsp_status_ff};
   assign rsp_tdata  = OUT_TDW'({rsp_inv_ff, rsp_adm_ff,
                                rsp_nm_ff[2], rsp_nm_ff[1], rsp_nm_ff[0],
                                rsp_cl_ff[2], rsp_cl_ff[1], rsp_cl_ff[0],
                                rsp_clr_ff});

   // ---------------------------------------------------------------------
   // Assertions.
   // ---------------------------------------------------------------------
   `SSCU_ASSERT_NEXT(a_accept_fills_front, clock, reset, req_tvalid && req_tready, a_valid_ff, "accepted beat did not enter the front stage")
   `SSCU_ASSERT_HOLDS(a_error_zeroes, clock, reset, rsp_valid_ff && rsp_status_ff != sscu_pkg::ST_OK, rsp_clr_ff == '0 && !rsp_sel_ff && !rsp_adm_ff && rsp_inv_ff == '0 && rsp_cl_ff[0] == '0 && rsp_nm_ff[0] == '0, "error result carries nonzero fields")
   `SSCU_ASSERT_HOLDS(a_admissible_sign, clock, reset, rsp_valid_ff && rsp_status_ff == sscu_pkg::ST_OK, rsp_adm_ff == !rsp_clr_ff[CW-1], "admissible flag disagrees with clearance sign")
   `SSCU_ASSERT_HOLDS(a_normal_unit, clock, reset, rsp_valid_ff, $signed(rsp_nm_ff[0]) <= $signed(NORM_ONE_OUT) && $signed(rsp_nm_ff[0]) >= -$signed(NORM_ONE_OUT), "normal component beyond one")

endmodule
`default_nettype wire
